// File: hdl/rsgc_pkg.sv
// Shared types, constants and index helpers of the readout sequence gap checker.
package rsgc_pkg;

  localparam int NUM_DTC   = 16;
  localparam int NUM_ROC   = 8;
  localparam int TAG_WIDTH = 48;

  localparam int LINKS   = NUM_DTC * NUM_ROC;
  localparam int DTC_AW  = (NUM_DTC > 1) ? $clog2(NUM_DTC) : 1;
  localparam int LINK_AW = (LINKS > 1) ? $clog2(LINKS) : 1;

  localparam int VALUE_W = 48;
  localparam int WORD_W  = 32;
  localparam int MARK_W  = 12;

  localparam logic [MARK_W-1:0] BEGIN_OK = 12'hAAA;

  typedef enum logic [1:0] {
    KIND_DTC_HDR  = 2'd0,
    KIND_ROC_HDR  = 2'd1,
    KIND_COUNTER  = 2'd2,
    KIND_TEST_HIT = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_DTC_GAP      = 3'd1,
    ST_ROC_GAP      = 3'd2,
    ST_BOUNDARY_GAP = 3'd3,
    ST_INTERNAL_GAP = 3'd4,
    ST_BAD_BEGIN    = 3'd5,
    ST_BAD_LAST     = 3'd6,
    ST_BAD_BOTH     = 3'd7
  } status_e;

  typedef struct packed {
    kind_e               kind;
    logic [3:0]          dtc_id;
    logic [2:0]          roc_id;
    logic [VALUE_W-1:0]  value;
    logic                first_in_block;
    logic                last_in_block;
    logic [MARK_W-1:0]   begin_marker;
    logic [MARK_W-1:0]   sample_marker;
  } item_t;

  typedef struct packed {
    status_e             status;
    logic [VALUE_W-1:0]  expected;
    logic                compared;
  } result_t;

  // Table writes and register updates that one item causes.
  typedef struct packed {
    logic                 dtc_we;
    logic                 roc_we;
    logic                 cnt_we;
    logic [TAG_WIDTH-1:0] tag;
    logic [WORD_W-1:0]    word;
    logic                 word_upd;
    logic                 gap_seen_d;
  } upd_t;

  function automatic logic dtc_in_range(logic [3:0] dtc_id);
    return 9'(dtc_id) < 9'(NUM_DTC);
  endfunction

  function automatic logic link_in_range(logic [3:0] dtc_id, logic [2:0] roc_id);
    return dtc_in_range(dtc_id) && (7'(roc_id) < 7'(NUM_ROC));
  endfunction

  function automatic logic [DTC_AW-1:0] dtc_index(logic [3:0] dtc_id);
    logic [7:0] full;
    full = 8'(dtc_id);
    return full[DTC_AW-1:0];
  endfunction

  function automatic logic [LINK_AW-1:0] link_index(logic [3:0] dtc_id, logic [2:0] roc_id);
    logic [15:0] full;
    full = 16'(dtc_id) * 16'(NUM_ROC) + 16'(roc_id);
    return full[LINK_AW-1:0];
  endfunction

  function automatic logic [TAG_WIDTH-1:0] to_tag(logic [VALUE_W-1:0] value);
    logic [63:0] wide;
    wide = 64'(value);
    return wide[TAG_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] tag_to_out(logic [TAG_WIDTH-1:0] tag);
    logic [63:0] wide;
    wide = 64'(tag);
    return wide[VALUE_W-1:0];
  endfunction

endpackage

// File: hdl/rsgc_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module rsgc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rsgc_eval.sv
// Check logic: compares one item with its stored predecessors and forms the updates.
module rsgc_eval import rsgc_pkg::*; (
  input  item_t                item_i,
  input  logic                 win_chk_en_i,
  input  logic [TAG_WIDTH-1:0] dtc_tag_i,
  input  logic                 dtc_seen_i,
  input  logic [TAG_WIDTH-1:0] roc_tag_i,
  input  logic                 roc_seen_i,
  input  logic [WORD_W-1:0]    cnt_word_i,
  input  logic                 cnt_seen_i,
  input  logic [WORD_W-1:0]    prev_word_i,
  input  logic                 gap_seen_i,
  output result_t              result_o,
  output upd_t                 upd_o
);

  logic                 dtc_ok;
  logic                 link_ok;
  logic [TAG_WIDTH-1:0] tag;
  logic [TAG_WIDTH-1:0] tag_exp;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    bnd_exp;
  logic [WORD_W-1:0]    int_exp;
  logic                 bad_begin;
  logic                 bad_last;

  assign dtc_ok    = dtc_in_range(item_i.dtc_id);
  assign link_ok   = link_in_range(item_i.dtc_id, item_i.roc_id);
  assign tag       = to_tag(item_i.value);
  assign tag_exp   = ((item_i.kind == KIND_DTC_HDR) ? dtc_tag_i : roc_tag_i) + 1'b1;
  assign word      = item_i.value[WORD_W-1:0];
  assign bnd_exp   = cnt_word_i + 1'b1;
  assign int_exp   = prev_word_i + 1'b1;
  assign bad_begin = item_i.begin_marker != BEGIN_OK;
  assign bad_last  = item_i.sample_marker == '0;

  always_comb begin
    result_o          = '{status: ST_OK, expected: '0, compared: 1'b0};
    upd_o             = '0;
    upd_o.tag         = tag;
    upd_o.word        = word;
    upd_o.gap_seen_d  = gap_seen_i;
    case (item_i.kind)
      KIND_DTC_HDR: begin
        if (win_chk_en_i && dtc_ok) begin
          upd_o.dtc_we = 1'b1;
          if (dtc_seen_i) begin
            result_o.expected = tag_to_out(tag_exp);
            result_o.compared = 1'b1;
            if (tag != tag_exp) begin
              result_o.status = ST_DTC_GAP;
            end
          end
        end
      end
      KIND_ROC_HDR: begin
        if (win_chk_en_i && link_ok) begin
          upd_o.roc_we = 1'b1;
          if (roc_seen_i) begin
            result_o.expected = tag_to_out(tag_exp);
            result_o.compared = 1'b1;
            if (tag != tag_exp) begin
              result_o.status = ST_ROC_GAP;
            end
          end
        end
      end
      KIND_COUNTER: begin
        upd_o.word_upd = 1'b1;
        upd_o.cnt_we   = item_i.last_in_block && win_chk_en_i && link_ok;
        if (item_i.first_in_block) begin
          upd_o.gap_seen_d = 1'b0;
          if (win_chk_en_i && link_ok && cnt_seen_i) begin
            result_o.expected = VALUE_W'(bnd_exp);
            result_o.compared = 1'b1;
            if (word != bnd_exp) begin
              result_o.status = ST_BOUNDARY_GAP;
            end
          end
        end else begin
          result_o.expected = VALUE_W'(int_exp);
          result_o.compared = 1'b1;
          // Only the first break inside a block is flagged.
          if (word != int_exp && !gap_seen_i) begin
            result_o.status  = ST_INTERNAL_GAP;
            upd_o.gap_seen_d = 1'b1;
          end
        end
      end
      default: begin
        if (bad_begin && bad_last) begin
          result_o.status = ST_BAD_BOTH;
        end else if (bad_begin) begin
          result_o.status = ST_BAD_BEGIN;
        end else if (bad_last) begin
          result_o.status = ST_BAD_LAST;
        end
      end
    endcase
  end

endmodule

// File: hdl/readout_sequence_gap_checker.sv
// Readout sequence gap checker: takes one decoded readout item per cycle while the output
// is not stalled and returns one status result per item. The block accepts a new request in
// every cycle in which its check stage is empty or can pass its result on. Each request goes
// through a synchronous read of the controller tag, link tag and link counter tables, then the
// check itself, whose updates are written back as its result is registered and forwarded to a
// request that read the same entry in the meantime. Valid bits of the tables are flip-flops
// cleared by reset, so the block is ready right after reset with no clearing pass. The result
// register lets the next request enter while a finished result waits on the output side.
module readout_sequence_gap_checker import rsgc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // window and cross-block counter check enable
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // dtc_id[3:0], roc_id[6:4], value[54:7], first_in_block[55],
  // begin_marker[67:56], sample_marker[79:68]
  input  logic [79:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,     // kind[1:0]
  input  logic        s_axis_tlast,     // last_in_block
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], expected[50:3], compared[51], zero[55:52]
  output logic [55:0] m_axis_tdata
);

  item_t                in_item;
  logic                 accept;
  logic                 out_free;
  logic                 s1_fire;

  logic                 win_chk_en_q;
  logic                 s1_vld_q, s1_vld_d;
  item_t                s1_item_q;
  logic                 out_vld_q, out_vld_d;
  result_t              out_res_q;

  logic [LINKS-1:0]     roc_seen_q;
  logic [LINKS-1:0]     cnt_seen_q;
  logic [NUM_DTC-1:0]   dtc_seen_q;

  logic [WORD_W-1:0]    prev_word_q;
  logic                 gap_seen_q;

  // Last write to each table, used when the next request read that entry too early.
  logic                 dtc_fwd_vld_q;
  logic [DTC_AW-1:0]    dtc_fwd_addr_q;
  logic [TAG_WIDTH-1:0] dtc_fwd_data_q;
  logic                 roc_fwd_vld_q;
  logic [LINK_AW-1:0]   roc_fwd_addr_q;
  logic [TAG_WIDTH-1:0] roc_fwd_data_q;
  logic                 cnt_fwd_vld_q;
  logic [LINK_AW-1:0]   cnt_fwd_addr_q;
  logic [WORD_W-1:0]    cnt_fwd_data_q;

  logic [DTC_AW-1:0]    in_dtc_idx;
  logic [LINK_AW-1:0]   in_link_idx;
  logic [DTC_AW-1:0]    s1_dtc_idx;
  logic [LINK_AW-1:0]   s1_link_idx;

  logic [TAG_WIDTH-1:0] dtc_rdata, roc_rdata;
  logic [WORD_W-1:0]    cnt_rdata;
  logic [TAG_WIDTH-1:0] dtc_tag, roc_tag;
  logic [WORD_W-1:0]    cnt_word;

  result_t              res;
  upd_t                 upd;

  assign in_item.kind           = kind_e'(s_axis_tuser);
  assign in_item.dtc_id         = s_axis_tdata[3:0];
  assign in_item.roc_id         = s_axis_tdata[6:4];
  assign in_item.value          = s_axis_tdata[54:7];
  assign in_item.first_in_block = s_axis_tdata[55];
  assign in_item.last_in_block  = s_axis_tlast;
  assign in_item.begin_marker   = s_axis_tdata[67:56];
  assign in_item.sample_marker  = s_axis_tdata[79:68];

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s1_fire       = s1_vld_q && out_free;
  assign s_axis_tready = !s1_vld_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_dtc_idx  = dtc_index(in_item.dtc_id);
  assign in_link_idx = link_index(in_item.dtc_id, in_item.roc_id);
  assign s1_dtc_idx  = dtc_index(s1_item_q.dtc_id);
  assign s1_link_idx = link_index(s1_item_q.dtc_id, s1_item_q.roc_id);

  rsgc_ram #(.DEPTH(NUM_DTC), .WIDTH(TAG_WIDTH)) u_dtc_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire && upd.dtc_we),
    .waddr_i (s1_dtc_idx),
    .wdata_i (upd.tag),
    .re_i    (accept),
    .raddr_i (in_dtc_idx),
    .rdata_o (dtc_rdata)
  );

  rsgc_ram #(.DEPTH(LINKS), .WIDTH(TAG_WIDTH)) u_roc_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire && upd.roc_we),
    .waddr_i (s1_link_idx),
    .wdata_i (upd.tag),
    .re_i    (accept),
    .raddr_i (in_link_idx),
    .rdata_o (roc_rdata)
  );

  rsgc_ram #(.DEPTH(LINKS), .WIDTH(WORD_W)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire && upd.cnt_we),
    .waddr_i (s1_link_idx),
    .wdata_i (upd.word),
    .re_i    (accept),
    .raddr_i (in_link_idx),
    .rdata_o (cnt_rdata)
  );

  // The forward registers always hold the newest write, so they are never older than the RAM.
  assign dtc_tag  = (dtc_fwd_vld_q && dtc_fwd_addr_q == s1_dtc_idx) ? dtc_fwd_data_q
                                                                    : dtc_rdata;
  assign roc_tag  = (roc_fwd_vld_q && roc_fwd_addr_q == s1_link_idx) ? roc_fwd_data_q
                                                                     : roc_rdata;
  assign cnt_word = (cnt_fwd_vld_q && cnt_fwd_addr_q == s1_link_idx) ? cnt_fwd_data_q
                                                                     : cnt_rdata;

  rsgc_eval u_eval (
    .item_i       (s1_item_q),
    .win_chk_en_i (win_chk_en_q),
    .dtc_tag_i    (dtc_tag),
    .dtc_seen_i   (dtc_seen_q[s1_dtc_idx]),
    .roc_tag_i    (roc_tag),
    .roc_seen_i   (roc_seen_q[s1_link_idx]),
    .cnt_word_i   (cnt_word),
    .cnt_seen_i   (cnt_seen_q[s1_link_idx]),
    .prev_word_i  (prev_word_q),
    .gap_seen_i   (gap_seen_q),
    .result_o     (res),
    .upd_o        (upd)
  );

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_fire) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (s1_fire) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_chk_en_q  <= 1'b0;
      s1_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      dtc_seen_q    <= '0;
      roc_seen_q    <= '0;
      cnt_seen_q    <= '0;
      prev_word_q   <= '0;
      gap_seen_q    <= 1'b0;
      dtc_fwd_vld_q <= 1'b0;
      roc_fwd_vld_q <= 1'b0;
      cnt_fwd_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        win_chk_en_q <= cfg_wdata_i;
      end
      if (s1_fire) begin
        gap_seen_q <= upd.gap_seen_d;
        if (upd.word_upd) begin
          prev_word_q <= upd.word;
        end
        if (upd.dtc_we) begin
          dtc_seen_q[s1_dtc_idx] <= 1'b1;
          dtc_fwd_vld_q          <= 1'b1;
        end
        if (upd.roc_we) begin
          roc_seen_q[s1_link_idx] <= 1'b1;
          roc_fwd_vld_q           <= 1'b1;
        end
        if (upd.cnt_we) begin
          cnt_seen_q[s1_link_idx] <= 1'b1;
          cnt_fwd_vld_q           <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item;
    end
    if (s1_fire) begin
      out_res_q <= res;
      if (upd.dtc_we) begin
        dtc_fwd_addr_q <= s1_dtc_idx;
        dtc_fwd_data_q <= upd.tag;
      end
      if (upd.roc_we) begin
        roc_fwd_addr_q <= s1_link_idx;
        roc_fwd_data_q <= upd.tag;
      end
      if (upd.cnt_we) begin
        cnt_fwd_addr_q <= s1_link_idx;
        cnt_fwd_data_q <= upd.word;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_res_q.compared, out_res_q.expected, out_res_q.status};

endmodule

// File: hdl/rsgc_sva.sv
// Port-level checker for the readout sequence gap checker, bound to the top level.
module rsgc_sva import rsgc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  logic       in_hs, out_hs;
  logic [1:0] outst_q;
  logic [2:0] st;

  assign in_hs  = s_axis_tvalid && s_axis_tready;
  assign out_hs = m_axis_tvalid && m_axis_tready;
  assign st     = m_axis_tdata[2:0];

  // Requests accepted but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_q + 2'(in_hs) - 2'(out_hs);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs |-> outst_q != 2'd0)
    else $error("result without a pending request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q != 2'd3)
    else $error("more than two requests in flight");

  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_BAD_BEGIN || st == ST_BAD_LAST || st == ST_BAD_BOTH)
    |-> !m_axis_tdata[51] && m_axis_tdata[50:3] == '0)
    else $error("marker status carries a comparison");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_DTC_GAP || st == ST_ROC_GAP ||
                      st == ST_BOUNDARY_GAP || st == ST_INTERNAL_GAP)
    |-> m_axis_tdata[51])
    else $error("gap status without a comparison");

endmodule

bind readout_sequence_gap_checker rsgc_sva u_rsgc_sva (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench of the readout sequence gap checker: directed table, then random streams.
`timescale 1ns / 1ps

module testbench;
  import rsgc_pkg::*;

  typedef struct {
    bit      is_cfg;
    bit      cfg_val;
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  readout_sequence_gap_checker uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: window tags, link counters and the running block state.
  bit                 ewts_en = 1'b0;
  logic [47:0]        dtc_tag_mem [NUM_DTC];
  bit                 dtc_tag_seen [NUM_DTC];
  logic [47:0]        roc_tag_mem [LINKS];
  bit                 roc_tag_seen [LINKS];
  logic [31:0]        link_cnt_mem [LINKS];
  bit                 link_cnt_seen [LINKS];
  logic [31:0]        prev_word = '0;
  bit                 block_gap_flag = 1'b0;

  result_t            pending_status_q [$];
  int                 mismatch_count = 0;
  int                 results_checked = 0;
  int                 burst_left = 0;

  // Stream generator state, kept apart from the predictor so that gaps can be injected.
  logic [47:0]        gen_dtc_tag [NUM_DTC];
  logic [47:0]        gen_roc_tag [LINKS];
  logic [31:0]        gen_cnt [LINKS];
  item_t              stream_q [$];
  row_t               directed_rows [$];

  function automatic result_t predict_status(item_t it);
    result_t     r;
    bit          dtc_ok;
    bit          link_ok;
    int          link;
    logic [31:0] word;
    logic [31:0] nxt;
    r = '0;
    r.status = ST_OK;
    dtc_ok = int'(it.dtc_id) < NUM_DTC;
    link_ok = dtc_ok && (int'(it.roc_id) < NUM_ROC);
    link = int'(it.dtc_id) * NUM_ROC + int'(it.roc_id);
    case (it.kind)
      KIND_DTC_HDR: begin
        if (ewts_en && dtc_ok) begin
          if (dtc_tag_seen[it.dtc_id]) begin
            r.expected = dtc_tag_mem[it.dtc_id] + 48'd1;
            r.compared = 1'b1;
            if (it.value != r.expected) r.status = ST_DTC_GAP;
          end
          dtc_tag_mem[it.dtc_id] = it.value;
          dtc_tag_seen[it.dtc_id] = 1'b1;
        end
      end
      KIND_ROC_HDR: begin
        if (ewts_en && link_ok) begin
          if (roc_tag_seen[link]) begin
            r.expected = roc_tag_mem[link] + 48'd1;
            r.compared = 1'b1;
            if (it.value != r.expected) r.status = ST_ROC_GAP;
          end
          roc_tag_mem[link] = it.value;
          roc_tag_seen[link] = 1'b1;
        end
      end
      KIND_COUNTER: begin
        word = it.value[31:0];
        if (it.first_in_block) begin
          block_gap_flag = 1'b0;
          if (ewts_en && link_ok && link_cnt_seen[link]) begin
            nxt = link_cnt_mem[link] + 32'd1;
            r.expected = {16'h0, nxt};
            r.compared = 1'b1;
            if (word != nxt) r.status = ST_BOUNDARY_GAP;
          end
        end else begin
          // Only the first internal gap of a block is flagged.
          nxt = prev_word + 32'd1;
          r.expected = {16'h0, nxt};
          r.compared = 1'b1;
          if (word != nxt && !block_gap_flag) begin
            r.status = ST_INTERNAL_GAP;
            block_gap_flag = 1'b1;
          end
        end
        prev_word = word;
        if (it.last_in_block && ewts_en && link_ok) begin
          link_cnt_mem[link] = word;
          link_cnt_seen[link] = 1'b1;
        end
      end
      default: begin
        if (it.begin_marker != BEGIN_OK && it.sample_marker == '0) r.status = ST_BAD_BOTH;
        else if (it.begin_marker != BEGIN_OK) r.status = ST_BAD_BEGIN;
        else if (it.sample_marker == '0) r.status = ST_BAD_LAST;
      end
    endcase
    return r;
  endfunction

  function automatic item_t mk(kind_e kind, int dtc, int roc, logic [47:0] value,
                               bit first, bit last, logic [11:0] bm, logic [11:0] sm);
    item_t it;
    it.kind = kind;
    it.dtc_id = 4'(dtc);
    it.roc_id = 3'(roc);
    it.value = value;
    it.first_in_block = first;
    it.last_in_block = last;
    it.begin_marker = bm;
    it.sample_marker = sm;
    return it;
  endfunction

  function automatic result_t res(status_e st, logic [47:0] expected, bit compared);
    result_t r;
    r.status = st;
    r.expected = expected;
    r.compared = compared;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic item_t random_item();
    return mk(kind_e'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 7),
              rand48(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    if (mismatch_count < 100)
      $display("[%0t] mismatch in %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(logic [55:0] word);
    result_t want;
    if (pending_status_q.size() == 0) begin
      report_mismatch("unexpected result", word[47:0], '0);
    end else begin
      want = pending_status_q.pop_front();
      if (word[2:0] != want.status)
        report_mismatch("status", 48'(word[2:0]), 48'(want.status));
      if (word[50:3] != want.expected) report_mismatch("expected", word[50:3], want.expected);
      if (word[51] != want.compared)
        report_mismatch("compared", 48'(word[51]), 48'(want.compared));
    end
    results_checked++;
  endtask

  // Offers one request and holds it until it is taken; valid stays high on return.
  task automatic offer(input item_t it, input bit typed, input result_t want);
    result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.sample_marker, it.begin_marker, it.first_in_block, it.value,
                      it.roc_id, it.dtc_id};
    s_axis_tuser  <= it.kind;
    s_axis_tlast  <= it.last_in_block;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_status(it);
    pending_status_q.insert(pending_status_q.size(), typed ? want : r);
  endtask

  task automatic send_paced(input item_t it);
    int gap;
    offer(it, 1'b0, '0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Lowers valid and waits until every request has its result.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_cfg(bit val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ewts_en = val;
  endtask

  // One controller record: header, a few links each with a header and a counter block,
  // some test hits, and now and then stray items.
  function automatic void build_record();
    int          d;
    int          l;
    int          n;
    item_t       it;
    logic [31:0] cnt;
    bit          keep_last;
    d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    gen_dtc_tag[d] = gen_dtc_tag[d] + (($urandom_range(0, 9) == 0) ? rand48() : 48'd1);
    it = random_item();
    it.kind = KIND_DTC_HDR;
    it.dtc_id = 4'(d);
    it.value = gen_dtc_tag[d];
    stream_q.insert(stream_q.size(), it);
    repeat ($urandom_range(1, 3)) begin
      it = random_item();
      l = d * NUM_ROC + int'(it.roc_id);
      gen_roc_tag[l] = gen_roc_tag[l] + (($urandom_range(0, 9) == 0) ? rand48() : 48'd1);
      it.kind = KIND_ROC_HDR;
      it.dtc_id = 4'(d);
      it.value = gen_roc_tag[l];
      stream_q.insert(stream_q.size(), it);
      n = $urandom_range(1, 6);
      keep_last = $urandom_range(0, 9) != 0;
      cnt = gen_cnt[l] + (($urandom_range(0, 9) == 0) ? $urandom() : 32'd1);
      for (int i = 0; i < n; i++) begin
        it.kind = KIND_COUNTER;
        it.value = {16'($urandom()), cnt};
        it.first_in_block = (i == 0) ? ($urandom_range(0, 14) != 0) : 1'b0;
        it.last_in_block = (i == n - 1) && keep_last;
        it.begin_marker = 12'($urandom_range(0, 4095));
        it.sample_marker = 12'($urandom_range(0, 4095));
        stream_q.insert(stream_q.size(), it);
        if (it.last_in_block) gen_cnt[l] = cnt;
        cnt = cnt + (($urandom_range(0, 7) == 0) ? $urandom_range(2, 9) : 32'd1);
      end
    end
    repeat ($urandom_range(0, 2)) begin
      it = random_item();
      it.kind = KIND_TEST_HIT;
      if ($urandom_range(0, 5) != 0) it.begin_marker = BEGIN_OK;
      it.sample_marker = ($urandom_range(0, 5) == 0) ? 12'h0 : 12'($urandom_range(1, 4095));
      stream_q.insert(stream_q.size(), it);
    end
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 2)) stream_q.insert(stream_q.size(), random_item());
  endfunction

  initial begin : result_side
    int mode;
    int mode_left;
    int hold_left;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_checked >= 400) begin
        // Long hold-off so the pipeline fills and back-pressures the input.
        hold_done = 1'b1;
        hold_left = 300;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 100);
        end
        mode_left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int sent;
    for (int i = 0; i < NUM_DTC; i++) gen_dtc_tag[i] = rand48();
    for (int i = 0; i < LINKS; i++) begin
      gen_roc_tag[i] = ($urandom_range(0, 3) == 0) ? 48'hFFFF_FFFF_FFFC : rand48();
      gen_cnt[i] = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFD : $urandom();
    end

    add_row('{1'b1, 1'b1, '0, 1'b0, '0});
    add_row('{0, 0, mk(KIND_TEST_HIT, 0, 0, 0, 0, 0, BEGIN_OK, 12'h001),
              1, res(ST_OK, 0, 0)});
    add_row('{0, 0, mk(KIND_TEST_HIT, 1, 1, 0, 0, 0, 12'h000, 12'hFFF),
              1, res(ST_BAD_BEGIN, 0, 0)});
    add_row('{0, 0, mk(KIND_TEST_HIT, 2, 2, 0, 0, 0, BEGIN_OK, 12'h000),
              1, res(ST_BAD_LAST, 0, 0)});
    add_row('{0, 0, mk(KIND_TEST_HIT, 3, 3, 0, 1, 1, 12'hFFF, 12'h000),
              1, res(ST_BAD_BOTH, 0, 0)});
    // Controller tag: unseen entry, wrap at the tag width, then a gap.
    add_row('{0, 0, mk(KIND_DTC_HDR, 0, 0, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0),
              1, res(ST_OK, 0, 0)});
    add_row('{0, 0, mk(KIND_DTC_HDR, 0, 5, 48'h0, 0, 0, 0, 0),
              1, res(ST_OK, 48'h0, 1)});
    add_row('{0, 0, mk(KIND_DTC_HDR, 0, 0, 48'h5, 0, 0, 0, 0),
              1, res(ST_DTC_GAP, 48'h1, 1)});
    add_row('{0, 0, mk(KIND_DTC_HDR, 15, 7, 48'h123, 1, 1, 0, 0),
              1, res(ST_OK, 0, 0)});
    add_row('{0, 0, mk(KIND_ROC_HDR, 15, 7, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0),
              1, res(ST_OK, 0, 0)});
    add_row('{0, 0, mk(KIND_ROC_HDR, 15, 7, 48'h0, 0, 0, 0, 0),
              1, res(ST_OK, 48'h0, 1)});
    add_row('{0, 0, mk(KIND_ROC_HDR, 15, 7, 48'h7, 0, 0, 0, 0),
              1, res(ST_ROC_GAP, 48'h1, 1)});
    // Counter blocks on one link: wrap, boundary gap, first and later internal gaps.
    add_row('{0, 0, mk(KIND_COUNTER, 3, 2, 48'hFFFF_FFFE, 1, 0, 0, 0),
              1, res(ST_OK, 0, 0)});
    add_row('{0, 0, mk(KIND_COUNTER, 3, 2, 48'hFFFF_FFFF, 0, 0, 0, 0),
              0, '0});
    add_row('{0, 0, mk(KIND_COUNTER, 3, 2, 48'h0, 0, 1, 0, 0),
              1, res(ST_OK, 48'h0, 1)});
    add_row('{0, 0, mk(KIND_COUNTER, 3, 2, 48'hABCD_0000_0005, 1, 0, 0, 0),
              1, res(ST_BOUNDARY_GAP, 48'h1, 1)});
    add_row('{0, 0, mk(KIND_COUNTER, 3, 2, 48'h9, 0, 0, 0, 0),
              1, res(ST_INTERNAL_GAP, 48'h6, 1)});
    add_row('{0, 0, mk(KIND_COUNTER, 3, 2, 48'd20, 0, 0, 0, 0),
              1, res(ST_OK, 48'd10, 1)});
    add_row('{0, 0, mk(KIND_COUNTER, 3, 2, 48'd21, 0, 1, 0, 0), 0, '0});
    add_row('{0, 0, mk(KIND_COUNTER, 3, 2, 48'd22, 1, 1, 0, 0),
              1, res(ST_OK, 48'd22, 1)});
    // With checks off, headers pass untouched and the link counter is not stored.
    add_row('{1'b1, 1'b0, '0, 1'b0, '0});
    add_row('{0, 0, mk(KIND_DTC_HDR, 0, 0, 48'd100, 0, 0, 0, 0),
              1, res(ST_OK, 0, 0)});
    add_row('{0, 0, mk(KIND_COUNTER, 3, 2, 48'd99, 1, 1, 0, 0),
              1, res(ST_OK, 0, 0)});
    add_row('{0, 0, mk(KIND_COUNTER, 3, 2, 48'd50, 0, 0, 0, 0),
              1, res(ST_INTERNAL_GAP, 48'd100, 1)});
    add_row('{1'b1, 1'b1, '0, 1'b0, '0});
    add_row('{0, 0, mk(KIND_COUNTER, 3, 2, 48'd23, 1, 0, 0, 0), 0, '0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain();
        write_cfg(directed_rows[i].cfg_val);
      end else begin
        offer(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random streams in four phases, alternating the check enable.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      write_cfg(phase % 2 == 0);
      sent = 0;
      while (sent < 225) begin
        build_record();
        while (stream_q.size() != 0) begin
          send_paced(stream_q.pop_front());
          sent++;
        end
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: readout_sequence_gap_checker.f
hdl/rsgc_pkg.sv
hdl/rsgc_ram.sv
hdl/rsgc_eval.sv
hdl/readout_sequence_gap_checker.sv
hdl/rsgc_sva.sv
tb/sv/testbench.sv
